// ===== design/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, codes and shared types.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package spq_pkg;

    // Queue depth and occupancy counter width (holds 0 .. CAPACITY)
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int COUNT_FIELD_W = 5;

    // Request opcodes
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Response status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } t_status;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry item;
    } t_cell_ctrl;

endpackage

// ===== design/spq_if.sv =====
// Handshake interfaces for the request and response channels.
// Depends on spq_pkg for field widths and codes.
`timescale 1ns / 1ps

interface spq_req_if;
    logic                                  valid;
    logic                                  ready;
    spq_pkg::t_cmd                         cmd;
    logic signed [spq_pkg::DATA_W-1:0]     item_data;
    logic signed [spq_pkg::PRIO_W-1:0]     item_priority;

    modport source (output valid, cmd, item_data, item_priority, input ready);
    modport sink   (input valid, cmd, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [spq_pkg::DATA_W-1:0]        popped_data;
    logic signed [spq_pkg::DATA_W-1:0]        head_data;
    logic signed [spq_pkg::PRIO_W-1:0]        head_priority;
    logic        [spq_pkg::COUNT_FIELD_W-1:0] count;
    logic                                     is_empty;
    spq_pkg::t_status                         status;

    modport source (output valid, popped_data, head_data, head_priority, count,
                    is_empty, status, input ready);
    modport sink   (input valid, popped_data, head_data, head_priority, count,
                    is_empty, status, output ready);
endinterface

// ===== design/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: occupancy counter, chain of
// spq_cell slots and the response register. Depends on spq_pkg, spq_if.
//
// Usage:
//   i_req carries push or pop requests (cmd, item_data, item_priority);
//   o_rsp returns one response per request: popped data, the head after
//   the operation, the count, an empty flag and a status code.
//   Entries sit in a row of cells sorted by ascending signed priority; a
//   push shifts every cell behind the insertion point one place right, a
//   pop shifts the whole row one place left. Every cell compares its own
//   priority against the pushed one in parallel.
//   The response is registered and appears in the cycle after the request is
//   accepted; one request per cycle is accepted while the receiver does not stall.
//   Push when full and pop when empty leave the queue unchanged and are
//   reported in status.
//   Reset clears the occupancy counter and the response valid; slot
//   contents are not reset.
//   When the receiver stalls the response register holds, and i_req.ready
//   drops until the response is taken; a new request is accepted in the
//   same cycle that the pending response is taken.
`timescale 1ns / 1ps

module sorted_priority_queue_top (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CAP = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      accept;
    logic                      is_push;
    logic                      is_pop;
    logic                      full;
    logic                      empty;
    spq_pkg::t_cell_ctrl       ctrl;
    spq_pkg::t_status          status;

    spq_pkg::t_entry cell_entry [CAP];
    spq_pkg::t_entry cell_next  [CAP];
    logic            cell_gt    [CAP];

    // Response register
    logic                                    r_rsp_valid;
    logic signed [spq_pkg::DATA_W-1:0]        r_popped;
    logic signed [spq_pkg::DATA_W-1:0]        r_head_data;
    logic signed [spq_pkg::PRIO_W-1:0]        r_head_prio;
    logic        [spq_pkg::COUNT_FIELD_W-1:0] r_count_out;
    logic                                     r_empty_out;
    spq_pkg::t_status                         r_status;

    // Handshake: take a request whenever the response slot is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign full    = (r_count == spq_pkg::CNT_W'(CAP));
    assign empty   = (r_count == '0);
    assign is_push = accept && (i_req.cmd == spq_pkg::CMD_PUSH);
    assign is_pop  = accept && (i_req.cmd == spq_pkg::CMD_POP);

    // Control broadcast to the chain
    always_comb begin
        ctrl.push      = is_push && !full;
        ctrl.pop       = is_pop && !empty;
        ctrl.item.data = i_req.item_data;
        ctrl.item.prio = i_req.item_priority;
    end

    // Status of the current request
    always_comb begin
        status = spq_pkg::STATUS_OK;
        if (is_push && full) begin
            status = spq_pkg::STATUS_PUSH_FULL;
        end else if (is_pop && empty) begin
            status = spq_pkg::STATUS_POP_EMPTY;
        end
    end

    // Occupancy after the operation
    always_comb begin
        n_count = r_count;
        if (ctrl.push) begin
            n_count = r_count + spq_pkg::CNT_W'(1);
        end else if (ctrl.pop) begin
            n_count = r_count - spq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Chain of cells; cell 0 is the head
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        spq_pkg::t_entry left;
        spq_pkg::t_entry right;
        logic            left_gt;
        logic            occupied;

        assign occupied = (r_count > spq_pkg::CNT_W'(g));

        if (g == 0) begin : g_first
            assign left    = '0;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left    = cell_entry[g-1];
            assign left_gt = cell_gt[g-1];
        end

        if (g == CAP - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_occupied (occupied),
            .i_left     (left),
            .i_left_gt  (left_gt),
            .i_right    (right),
            .o_entry    (cell_entry[g]),
            .o_next     (cell_next[g]),
            .o_gt       (cell_gt[g])
        );
    end

    // Response capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped    <= ctrl.pop ? cell_entry[0].data : '0;
            r_head_data <= (n_count != '0) ? cell_next[0].data : '0;
            r_head_prio <= (n_count != '0) ? cell_next[0].prio : '0;
            r_count_out <= spq_pkg::COUNT_FIELD_W'(32'(n_count));
            r_empty_out <= (n_count == '0);
            r_status    <= status;
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.popped_data   = r_popped;
    assign o_rsp.head_data     = r_head_data;
    assign o_rsp.head_priority = r_head_prio;
    assign o_rsp.count         = r_count_out;
    assign o_rsp.is_empty      = r_empty_out;
    assign o_rsp.status        = r_status;

endmodule

// ===== design/spq_cell.sv =====
// One slot of the sorted shift chain: holds an entry, shifts right on push
// behind the insertion point and left on pop. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_gt,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output spq_pkg::t_entry     o_next,
    output logic                o_gt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Empty slots count as greater, so the new item lands at the first
    // slot holding a strictly larger priority (ties stay in arrival order)
    assign o_gt = !i_occupied || (r_entry.prio > i_ctrl.item.prio);

    // Next entry: insert, shift from the left, or shift from the right
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push && o_gt) begin
            n_entry = i_left_gt ? i_left : i_ctrl.item;
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// ===== bench/spq_checker.sv =====
// Reply checker for the sorted priority queue: watches both channels, keeps
// its own sorted copy of the queue and compares every reply field by field.
// Depends on spq_pkg and the spq_req_if / spq_rsp_if interfaces.
`timescale 1ns / 1ps

module spq_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_req_if   i_req,
    spq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    // One predicted reply
    typedef struct {
        logic signed [spq_pkg::DATA_W-1:0]        popped_data;
        logic signed [spq_pkg::DATA_W-1:0]        head_data;
        logic signed [spq_pkg::PRIO_W-1:0]        head_priority;
        logic        [spq_pkg::COUNT_FIELD_W-1:0] count;
        logic                                     is_empty;
        spq_pkg::t_status                         status;
    } t_reply;

    // Shadow copy of the queue, kept sorted by ascending priority
    spq_pkg::t_entry shadow_slots [spq_pkg::CAPACITY];
    int              shadow_fill;
    t_reply          pending_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        shadow_fill  = 0;
    end

    // Apply one push or pop to the shadow queue and build the reply it gives
    function automatic t_reply apply_queue_op(spq_pkg::t_cmd op,
                                              logic signed [spq_pkg::DATA_W-1:0] data,
                                              logic signed [spq_pkg::PRIO_W-1:0] prio);
        t_reply r;
        int     pos;
        r.popped_data = '0;
        r.status      = spq_pkg::STATUS_OK;
        if (op == spq_pkg::CMD_PUSH) begin
            if (shadow_fill >= spq_pkg::CAPACITY) begin
                r.status = spq_pkg::STATUS_PUSH_FULL;
            end else begin
                // insert behind every entry of lower or equal priority
                pos = shadow_fill;
                for (int i = shadow_fill - 1; i >= 0; i--) begin
                    if (shadow_slots[i].prio > prio)
                        pos = i;
                end
                for (int i = shadow_fill; i > pos; i--)
                    shadow_slots[i] = shadow_slots[i-1];
                shadow_slots[pos].data = data;
                shadow_slots[pos].prio = prio;
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                r.status = spq_pkg::STATUS_POP_EMPTY;
            end else begin
                r.popped_data = shadow_slots[0].data;
                for (int i = 1; i < shadow_fill; i++)
                    shadow_slots[i-1] = shadow_slots[i];
                shadow_fill--;
            end
        end
        r.head_data     = (shadow_fill != 0) ? shadow_slots[0].data : '0;
        r.head_priority = (shadow_fill != 0) ? shadow_slots[0].prio : '0;
        r.count         = spq_pkg::COUNT_FIELD_W'(shadow_fill);
        r.is_empty      = (shadow_fill == 0);
        return r;
    endfunction

    task automatic check_field(string name, logic [spq_pkg::DATA_W-1:0] want,
                               logic [spq_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_fail_count++;
        end
    endtask

    // Requests feed the predictor; replies are matched against the oldest one
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                pending_replies.push_back(apply_queue_op(i_req.cmd, i_req.item_data,
                                                         i_req.item_priority));
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_replies.size() == 0) begin
                    $error("reply with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("popped_data", want.popped_data, i_rsp.popped_data);
                    check_field("head_data", want.head_data, i_rsp.head_data);
                    check_field("head_priority", want.head_priority, i_rsp.head_priority);
                    check_field("count", want.count, i_rsp.count);
                    check_field("is_empty", want.is_empty, i_rsp.is_empty);
                    check_field("status", want.status, i_rsp.status);
                    o_checked++;
                end
            end
            o_pending = pending_replies.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the sorted priority queue: clock, reset, request and
// reply handshakes, stimulus and verdict. Depends on spq_pkg, spq_if,
// spq_checker and sorted_priority_queue_top.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 217;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct = 12;
    int   snk_idle_pct = 76;
    int   cycle_count  = 0;
    int   n_push = 0;
    int   n_pop  = 0;
    int   fail_count;
    int   pending;
    int   checked;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    spq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Reply side: random stalls
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Priorities cluster on a few values so that ties are common
    function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
        logic [spq_pkg::PRIO_W-1:0] p;
        case ($urandom_range(9))
            0, 1, 2: p = spq_pkg::PRIO_W'($signed($urandom_range(4)) - 2);
            3:       p = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default: p = spq_pkg::PRIO_W'($urandom);
        endcase
        return p;
    endfunction

    // Present one request, with random idle cycles ahead of it
    task automatic send_request(input spq_pkg::t_cmd op,
                                input logic [spq_pkg::DATA_W-1:0] data,
                                input logic [spq_pkg::PRIO_W-1:0] prio);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= op;
        req_if.item_data     <= data;
        req_if.item_priority <= prio;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        if (op == spq_pkg::CMD_PUSH)
            n_push++;
        else
            n_pop++;
    endtask

    // Hold off until every outstanding reply has been taken
    task automatic wait_replies();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Random bursts, most leaning towards push or pop to sweep full and empty
    task automatic random_phase(input int n_items);
        int sent;
        int burst;
        int push_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(40, 10);
            case ($urandom_range(4))
                0: push_pct = 15;
                1: push_pct = 50;
                2: push_pct = 85;
                3: push_pct = 100;
                default: push_pct = 0;
            endcase
            for (int i = 0; i < burst && sent < n_items; i++) begin
                send_request(($urandom_range(99) < push_pct) ? spq_pkg::CMD_PUSH
                                                             : spq_pkg::CMD_POP,
                             $urandom, pick_priority());
                sent++;
            end
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.cmd           = spq_pkg::CMD_PUSH;
        req_if.item_data     = '0;
        req_if.item_priority = '0;
        rsp_if.ready         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pop on empty, extremes, ties, fill up, push on full
        send_request(spq_pkg::CMD_POP, 32'h1234_5678, 16'h0001);
        send_request(spq_pkg::CMD_PUSH, 32'h8000_0000, 16'h8000);
        send_request(spq_pkg::CMD_PUSH, 32'h7fff_ffff, 16'h7fff);
        send_request(spq_pkg::CMD_PUSH, 32'h0000_0000, 16'h0000);
        send_request(spq_pkg::CMD_PUSH, 32'hffff_ffff, 16'hffff);
        send_request(spq_pkg::CMD_PUSH, 32'h0000_0001, 16'h0005);
        send_request(spq_pkg::CMD_PUSH, 32'h0000_0002, 16'h0005);
        send_request(spq_pkg::CMD_PUSH, 32'h0000_0003, 16'h0005);
        send_request(spq_pkg::CMD_PUSH, 32'haaaa_5555, 16'h8000);
        send_request(spq_pkg::CMD_PUSH, 32'h5555_aaaa, 16'h7fff);
        for (int i = 0; i < 7; i++)
            send_request(spq_pkg::CMD_PUSH, $urandom, pick_priority());
        send_request(spq_pkg::CMD_PUSH, 32'hdead_beef, 16'h0000);
        repeat (6)
            send_request(spq_pkg::CMD_POP, $urandom, spq_pkg::PRIO_W'($urandom));
        wait_replies();

        random_phase(PHASE_ITEMS);
        wait_replies();

        src_idle_pct = 76;
        snk_idle_pct = 12;
        random_phase(PHASE_ITEMS);
        wait_replies();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(PHASE_ITEMS);
        wait_replies();

        repeat (4) @(posedge i_clk);
        $display("Covered %0d pushes and %0d pops (%0d replies checked)",
                 n_push, n_pop, checked);
        $display("under three stall patterns, with pop on empty, push on full and ties.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_top.f =====
design/spq_pkg.sv
design/spq_if.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
bench/spq_checker.sv
bench/tb.sv
